// File: design/ngqf_pkg.sv
// shared constants, codes and types for the n-gram query filter
package ngqf_pkg;

   localparam int MAX_QUERY = 6;
   localparam int MAX_GRAM  = 7;

   localparam int NUM_QTOK  = 6;
   localparam int NUM_WORDS = 7;
   localparam int TOKEN_W   = 32;
   localparam int WORD_W    = 31;
   localparam int MODE_W    = 2;
   localparam int QLEN_W    = 3;
   localparam int GLEN_W    = 3;
   localparam int CSR_IDX_W = 3;

   localparam int QCNT_W = $clog2(MAX_QUERY + 1);
   localparam int GCNT_W = $clog2(MAX_GRAM + 1);

   localparam logic [MODE_W-1:0] MODE_UNORDERED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ORDERED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PHRASE    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIXED     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MATCH_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_LENGTH = 3'd1;
   localparam int                   REG_TOKEN_BASE   = 2;

   localparam logic [TOKEN_W-1:0] WILDCARD = '1;

   typedef logic signed [TOKEN_W-1:0] token_type;
   typedef logic [WORD_W-1:0]         word_type;
   typedef word_type [NUM_WORDS-1:0]  words_type;

   typedef struct packed {
      logic [MODE_W-1:0]             mode;
      logic [QLEN_W-1:0]             qlen;
      token_type [NUM_QTOK-1:0]      tok;
   } cfg_type;

endpackage

// File: design/ngqf_csr.sv
// configuration registers: match mode, query length and query tokens
module ngqf_csr import ngqf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == REG_MATCH_MODE) begin
            cfg_in.mode = csr_data[MODE_W-1:0];
         end else if (csr_index == REG_QUERY_LENGTH) begin
            cfg_in.qlen = csr_data[QLEN_W-1:0];
         end
         for (int t = 0; t < NUM_QTOK; t++) begin
            if (csr_index == CSR_IDX_W'(REG_TOKEN_BASE + t)) begin
               cfg_in.tok[t] = csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_UNORDERED;
         cfg_ff.qlen <= '0;
         for (int t = 0; t < NUM_QTOK; t++) begin
            cfg_ff.tok[t] <= WILDCARD;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/ngqf_match.sv
// comparator matrix and the four match evaluators
module ngqf_match import ngqf_pkg::*; (
   input  cfg_type             cfg,
   input  logic [GLEN_W-1:0]   gram_len,
   input  words_type           words,
   output logic                hit
);

   logic [GCNT_W-1:0]       n_sat;
   logic [QCNT_W-1:0]       q_sat;
   logic [MAX_GRAM-1:0]     pos_ok;
   logic [MAX_QUERY-1:0]    q_act;
   logic [TOKEN_W-1:0]      qtok  [MAX_QUERY];
   logic [TOKEN_W-1:0]      gword [MAX_GRAM];
   logic [MAX_QUERY-1:0]    wc;
   logic [MAX_GRAM-1:0]     eq    [MAX_QUERY];
   logic [MAX_GRAM-1:0]     te    [MAX_QUERY];

   logic [MAX_GRAM-1:0]     cand_u [MAX_QUERY];
   logic [MAX_GRAM-1:0]     used;
   logic                    ok_u;
   logic [MAX_GRAM-1:0]     cand_o [MAX_QUERY];
   logic [MAX_GRAM-1:0]     low_o  [MAX_QUERY];
   logic [MAX_GRAM-1:0]     avail;
   logic                    ok_o;
   logic [MAX_GRAM-1:0]     win_ok;
   logic                    ok_p;
   logic                    ok_f;

   // saturate lengths
   always_comb begin
      if (int'(gram_len) > MAX_GRAM) begin
         n_sat = GCNT_W'(MAX_GRAM);
      end else begin
         n_sat = GCNT_W'(gram_len);
      end
      if (int'(cfg.qlen) > MAX_QUERY) begin
         q_sat = QCNT_W'(MAX_QUERY);
      end else begin
         q_sat = QCNT_W'(cfg.qlen);
      end
   end

   // query slots past the registers are wildcards, gram slots past the ports read zero
   for (genvar i = 0; i < MAX_QUERY; i++) begin : g_qtok
      if (i < NUM_QTOK) begin : g_reg
         assign qtok[i] = cfg.tok[i];
      end else begin : g_wild
         assign qtok[i] = WILDCARD;
      end
      assign q_act[i] = (i < int'(q_sat));
      assign wc[i]    = (qtok[i] == WILDCARD);
   end

   for (genvar j = 0; j < MAX_GRAM; j++) begin : g_word
      if (j < NUM_WORDS) begin : g_port
         assign gword[j] = {1'b0, words[j]};
      end else begin : g_zero
         assign gword[j] = '0;
      end
      assign pos_ok[j] = (j < int'(n_sat));
   end

   for (genvar i = 0; i < MAX_QUERY; i++) begin : g_row
      for (genvar j = 0; j < MAX_GRAM; j++) begin : g_col
         assign eq[i][j] = (qtok[i] == gword[j]);
      end
      assign te[i] = eq[i] | {MAX_GRAM{wc[i]}};
   end

   // unordered: each literal token claims the lowest free matching position
   always_comb begin
      used = '0;
      ok_u = 1'b1;
      for (int i = 0; i < MAX_QUERY; i++) begin
         cand_u[i] = eq[i] & pos_ok & ~used;
         if (q_act[i] && !wc[i]) begin
            if (cand_u[i] == '0) begin
               ok_u = 1'b0;
            end
            used = used | (cand_u[i] & (~cand_u[i] + 1'b1));
         end
      end
   end

   // ordered: take the first match at or after the cursor, then step past it
   always_comb begin
      avail = '1;
      ok_o  = 1'b1;
      for (int i = 0; i < MAX_QUERY; i++) begin
         cand_o[i] = te[i] & pos_ok & avail;
         low_o[i]  = cand_o[i] & (~cand_o[i] + 1'b1);
         if (q_act[i]) begin
            if (cand_o[i] == '0) begin
               ok_o = 1'b0;
            end
            avail = ~(low_o[i] | (low_o[i] - 1'b1));
         end
      end
   end

   // phrase: any start position whose window fits and matches
   always_comb begin
      for (int s = 0; s < MAX_GRAM; s++) begin
         win_ok[s] = (s + int'(q_sat) <= int'(n_sat));
         for (int k = 0; k < MAX_QUERY; k++) begin
            if (k < int'(q_sat)) begin
               if (s + k < MAX_GRAM) begin
                  if (!te[k][s + k]) begin
                     win_ok[s] = 1'b0;
                  end
               end else begin
                  win_ok[s] = 1'b0;
               end
            end
         end
      end
      ok_p = |win_ok;
   end

   // fixed: equal lengths and position by position
   always_comb begin
      ok_f = (int'(n_sat) == int'(q_sat));
      for (int k = 0; k < MAX_QUERY; k++) begin
         if (k < int'(q_sat)) begin
            if (k < MAX_GRAM) begin
               if (!te[k][k]) begin
                  ok_f = 1'b0;
               end
            end else begin
               ok_f = 1'b0;
            end
         end
      end
   end

   always_comb begin
      unique case (cfg.mode)
         MODE_UNORDERED: hit = ok_u;
         MODE_ORDERED:   hit = ok_o;
         MODE_PHRASE:    hit = ok_p;
         MODE_FIXED:     hit = ok_f;
         default:        hit = ok_f;
      endcase
   end

endmodule

// File: design/ngram_query_filter_unit.sv
// n-gram query filter: input register, match logic, result register
// an accepted beat passes through the input register, then the result register, to rsp
// throughput: one n-gram per cycle while rsp is not stalled, set by the single comparator matrix stage
// req_stall rises only when both registers are full and rsp is stalled
// reset (synchronous, active high) empties both stages and restores the
// configuration to unordered mode, empty query, all tokens wildcard
module ngram_query_filter_unit import ngqf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [GLEN_W-1:0]    req_gram_length,
   input  logic [WORD_W-1:0]    req_word_a,
   input  logic [WORD_W-1:0]    req_word_b,
   input  logic [WORD_W-1:0]    req_word_c,
   input  logic [WORD_W-1:0]    req_word_d,
   input  logic [WORD_W-1:0]    req_word_e,
   input  logic [WORD_W-1:0]    req_word_f,
   input  logic [WORD_W-1:0]    req_word_g,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_matches_res,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_data
);

   cfg_type           cfg;
   logic              in_valid_ff;
   logic [GLEN_W-1:0] in_len_ff;
   words_type         in_words_ff;
   words_type         req_words;
   logic              res_valid_ff;
   logic              res_match_ff;
   logic              match;
   logic              res_free;
   logic              req_take;

   assign req_words[0] = req_word_a;
   assign req_words[1] = req_word_b;
   assign req_words[2] = req_word_c;
   assign req_words[3] = req_word_d;
   assign req_words[4] = req_word_e;
   assign req_words[5] = req_word_f;
   assign req_words[6] = req_word_g;

   ngqf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ngqf_match u_match (
      .cfg      (cfg),
      .gram_len (in_len_ff),
      .words    (in_words_ff),
      .hit      (match)
   );

   assign res_free  = !res_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !res_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || res_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_len_ff   <= req_gram_length;
         in_words_ff <= req_words;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_free) begin
         res_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && in_valid_ff) begin
         res_match_ff <= match;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_matches_res = res_match_ff;

endmodule
